>>> rtl/core/time_decaying_bloom_filter_unit_assert.svh
// ----------------------------------------------------------------------------
// Time-decaying Bloom filter assertion macros
// Concurrent assertion wrappers that are compiled out under synthesis.
// ----------------------------------------------------------------------------
`ifndef TIME_DECAYING_BLOOM_FILTER_UNIT_ASSERT_SVH
`define TIME_DECAYING_BLOOM_FILTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define TDBF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define TDBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TDBF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`define TDBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/core/tdbf_pkg.sv
// ----------------------------------------------------------------------------
// Time-decaying Bloom filter package
// Shared types, request codes, controller states and control structures.
// ----------------------------------------------------------------------------
`default_nettype none

package tdbf_pkg;

    localparam int SLOTS      = 4096;
    localparam int SLOT_AW    = $clog2(SLOTS);
    localparam int MAX_HASHES = 8;
    localparam int HASH_AW    = $clog2(MAX_HASHES);
    localparam int CNT_W      = 4;
    localparam int REQ_W      = 4;
    localparam int TOTAL_W    = 13;
    localparam int TIMEOUT_W  = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd60;
    localparam logic [TOTAL_W-1:0]   TOTAL_MAX     = '1;

    typedef logic [REQ_W-1:0] req_code_t;

    localparam req_code_t REQ_ADD           = 4'd0;
    localparam req_code_t REQ_LOOKUP        = 4'd1;
    localparam req_code_t REQ_HAS_EXPIRED   = 4'd2;
    localparam req_code_t REQ_RESET_IF_EXP  = 4'd3;
    localparam req_code_t REQ_CLEAR_EXPIRED = 4'd4;
    localparam req_code_t REQ_COUNT_EXPIRED = 4'd5;
    localparam req_code_t REQ_COUNT_LIVE    = 4'd6;
    localparam req_code_t REQ_CLEAR_ALL     = 4'd7;
    localparam req_code_t REQ_TICK          = 4'd8;
    localparam req_code_t REQ_RESTART_TIME  = 4'd9;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [CNT_W-1:0]   index_count;
        logic [SLOT_AW-1:0] slot_index_0;
        logic [SLOT_AW-1:0] slot_index_1;
        logic [SLOT_AW-1:0] slot_index_2;
        logic [SLOT_AW-1:0] slot_index_3;
        logic [SLOT_AW-1:0] slot_index_4;
        logic [SLOT_AW-1:0] slot_index_5;
        logic [SLOT_AW-1:0] slot_index_6;
        logic [SLOT_AW-1:0] slot_index_7;
    } req_item_t;

    typedef struct packed {
        logic               present;
        logic               expired;
        logic [TOTAL_W-1:0] slot_total;
    } rsp_item_t;

    typedef enum logic [3:0] {
        ST_BOOT,
        ST_IDLE,
        ST_DISPATCH,
        ST_HREAD,
        ST_HEVAL,
        ST_HCHECK,
        ST_HWRITE,
        ST_SWEEP,
        ST_SDRAIN,
        ST_CLEAR,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load_req;
        logic hash_rd;
        logic hash_wr;
        logic k_rst;
        logic sweep_rd;
        logic reap_en;
        logic clr_wr;
        logic time_tick;
        logic time_zero;
        logic result_load;
    } dp_cmd_t;

    typedef struct packed {
        req_code_t req_type;
        logic      cnt_zero;
        logic      hash_last;
        logic      addr_last;
        logic      expired_hit;
        logic      rsp_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/tdbf_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tdbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/tdbf_ctrl.sv
// ----------------------------------------------------------------------------
// Time-decaying Bloom filter controller
// Sequences table clearing, hashed slot accesses, sweeps and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tdbf_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire tdbf_pkg::dp_status_t  status,
    output tdbf_pkg::dp_cmd_t          cmd
);

    import tdbf_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BOOT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_BOOT:
            begin
                if (status.addr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.req_type)
                    REQ_ADD:
                    begin
                        state_next = status.cnt_zero ? ST_DONE : ST_HWRITE;
                    end
                    REQ_LOOKUP, REQ_HAS_EXPIRED, REQ_RESET_IF_EXP:
                    begin
                        state_next = status.cnt_zero ? ST_DONE : ST_HREAD;
                    end
                    REQ_CLEAR_EXPIRED, REQ_COUNT_EXPIRED, REQ_COUNT_LIVE:
                    begin
                        state_next = ST_SWEEP;
                    end
                    REQ_CLEAR_ALL:
                    begin
                        state_next = ST_CLEAR;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_HREAD:
            begin
                if (status.hash_last)
                begin
                    state_next = ST_HEVAL;
                end
            end
            ST_HEVAL:
            begin
                state_next = ST_HCHECK;
            end
            ST_HCHECK:
            begin
                if (status.req_type == REQ_RESET_IF_EXP && status.expired_hit)
                begin
                    state_next = ST_HWRITE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_HWRITE:
            begin
                if (status.hash_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SWEEP:
            begin
                if (status.addr_last)
                begin
                    state_next = ST_SDRAIN;
                end
            end
            ST_SDRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                if (status.addr_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        unique case (state_reg)
            ST_BOOT:
            begin
                cmd.clr_wr = 1'b1;
            end
            ST_IDLE:
            begin
                req_stall    = 1'b0;
                cmd.load_req = req_valid;
            end
            ST_DISPATCH:
            begin
                cmd.time_tick = (status.req_type == REQ_TICK);
                cmd.time_zero = (status.req_type == REQ_RESTART_TIME)
                             || (status.req_type == REQ_CLEAR_ALL);
            end
            ST_HREAD:
            begin
                cmd.hash_rd = 1'b1;
            end
            ST_HEVAL:
            begin
            end
            ST_HCHECK:
            begin
                cmd.k_rst = 1'b1;
            end
            ST_HWRITE:
            begin
                cmd.hash_wr = 1'b1;
            end
            ST_SWEEP:
            begin
                cmd.sweep_rd = 1'b1;
                cmd.reap_en  = (status.req_type == REQ_CLEAR_EXPIRED);
            end
            ST_SDRAIN:
            begin
                cmd.reap_en = (status.req_type == REQ_CLEAR_EXPIRED);
            end
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
            end
            ST_DONE:
            begin
                cmd.result_load = status.rsp_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/tdbf_datapath.sv
// ----------------------------------------------------------------------------
// Time-decaying Bloom filter datapath
// Holds the stamp table, the time base, slot evaluation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdbf_datapath #(
    parameter int STAMP_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire tdbf_pkg::req_item_t                   req_data,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [tdbf_pkg::TIMEOUT_W-1:0]        cfg_wr_data,
    input  wire tdbf_pkg::dp_cmd_t                     cmd,
    output tdbf_pkg::dp_status_t                       status,
    output logic                                       rsp_valid,
    input  wire logic                                  rsp_stall,
    output tdbf_pkg::rsp_item_t                        rsp_data
);

    import tdbf_pkg::*;

    localparam int CMP_W = (STAMP_BITS > TIMEOUT_W) ? STAMP_BITS : TIMEOUT_W;
    localparam logic [STAMP_BITS-1:0] STAMP_TOP = '1;
    localparam logic [STAMP_BITS-1:0] STAMP_ONE = STAMP_BITS'(1);
    localparam logic [STAMP_BITS:0]   ELAPSED_LIMIT = {1'b0, STAMP_TOP};

    req_code_t           req_type_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SLOT_AW-1:0]  idx_reg [MAX_HASHES];
    logic [HASH_AW-1:0]  hash_k_reg;
    logic [SLOT_AW-1:0]  addr_reg;
    logic                rd_pend_reg;
    logic [SLOT_AW-1:0]  rd_addr_reg;
    logic                present_flag_reg;
    logic                expired_flag_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [STAMP_BITS:0] elapsed_reg;
    logic [STAMP_BITS-1:0] cur_stamp_reg;
    logic                rsp_valid_reg;
    rsp_item_t           rsp_data_reg;

    logic [CNT_W-1:0]      cnt_sat;
    logic [SLOT_AW-1:0]    hash_addr;
    logic                  ram_wr_en;
    logic [SLOT_AW-1:0]    ram_wr_addr;
    logic [STAMP_BITS-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [SLOT_AW-1:0]    ram_rd_addr;
    logic [STAMP_BITS-1:0] ram_rd_data;
    logic [STAMP_BITS:0]   age_diff;
    logic [STAMP_BITS-1:0] age;
    logic                  slot_used;
    logic                  age_over;
    logic                  slot_live;
    logic                  slot_stale;
    logic                  count_hit;
    logic                  is_sweep;
    logic                  in_time;

    assign cnt_sat = (req_data.index_count > CNT_W'(MAX_HASHES))
                   ? CNT_W'(MAX_HASHES) : req_data.index_count;

    assign hash_addr = idx_reg[hash_k_reg];

    assign age_diff   = {1'b0, cur_stamp_reg} - {1'b0, ram_rd_data};
    assign age        = age_diff[STAMP_BITS] ? (age_diff[STAMP_BITS-1:0] + STAMP_TOP)
                                             : age_diff[STAMP_BITS-1:0];
    assign slot_used  = (ram_rd_data != '0);
    assign age_over   = CMP_W'(age) > CMP_W'(timeout_reg);
    assign slot_live  = slot_used && !age_over;
    assign slot_stale = slot_used && age_over;

    assign is_sweep = (req_type_reg == REQ_CLEAR_EXPIRED)
                   || (req_type_reg == REQ_COUNT_EXPIRED)
                   || (req_type_reg == REQ_COUNT_LIVE);
    assign count_hit = (req_type_reg == REQ_COUNT_LIVE) ? slot_live : slot_stale;
    assign in_time   = (elapsed_reg <= ELAPSED_LIMIT);

    always_comb
    begin
        ram_rd_en   = cmd.hash_rd || cmd.sweep_rd;
        ram_rd_addr = cmd.hash_rd ? hash_addr : addr_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = addr_reg;
        ram_wr_data = '0;
        if (cmd.hash_wr)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = hash_addr;
            ram_wr_data = cur_stamp_reg;
        end
        else if (cmd.clr_wr)
        begin
            ram_wr_en = 1'b1;
        end
        else if (cmd.reap_en && rd_pend_reg && slot_stale)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = rd_addr_reg;
        end
    end

    tdbf_ram #(
        .WIDTH (STAMP_BITS),
        .DEPTH (SLOTS)
    ) u_stamp_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg <= req_data.req_type;
            cnt_reg      <= cnt_sat;
            idx_reg[0]   <= req_data.slot_index_0;
            idx_reg[1]   <= req_data.slot_index_1;
            idx_reg[2]   <= req_data.slot_index_2;
            idx_reg[3]   <= req_data.slot_index_3;
            idx_reg[4]   <= req_data.slot_index_4;
            idx_reg[5]   <= req_data.slot_index_5;
            idx_reg[6]   <= req_data.slot_index_6;
            idx_reg[7]   <= req_data.slot_index_7;
        end
        if (ram_rd_en)
        begin
            rd_addr_reg <= ram_rd_addr;
        end
        if (cmd.result_load)
        begin
            rsp_data_reg.present    <= (req_type_reg == REQ_LOOKUP)
                                    && present_flag_reg && in_time;
            rsp_data_reg.expired    <= ((req_type_reg == REQ_HAS_EXPIRED)
                                    || (req_type_reg == REQ_RESET_IF_EXP))
                                    && expired_flag_reg;
            rsp_data_reg.slot_total <= is_sweep ? total_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_k_reg       <= '0;
            addr_reg         <= '0;
            rd_pend_reg      <= 1'b0;
            present_flag_reg <= 1'b1;
            expired_flag_reg <= 1'b0;
            total_reg        <= '0;
            timeout_reg      <= TIMEOUT_RESET;
            elapsed_reg      <= '0;
            cur_stamp_reg    <= STAMP_ONE;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= ram_rd_en;

            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end

            if (cmd.load_req || cmd.k_rst)
            begin
                hash_k_reg <= '0;
            end
            else if (cmd.hash_rd || cmd.hash_wr)
            begin
                hash_k_reg <= hash_k_reg + HASH_AW'(1);
            end

            if (cmd.load_req)
            begin
                addr_reg <= '0;
            end
            else if (cmd.sweep_rd || cmd.clr_wr)
            begin
                addr_reg <= addr_reg + SLOT_AW'(1);
            end

            if (cmd.load_req)
            begin
                present_flag_reg <= 1'b1;
                expired_flag_reg <= 1'b0;
                total_reg        <= '0;
            end
            else if (rd_pend_reg)
            begin
                present_flag_reg <= present_flag_reg && slot_live;
                expired_flag_reg <= expired_flag_reg || slot_stale;
                if (count_hit && total_reg != TOTAL_MAX)
                begin
                    total_reg <= total_reg + TOTAL_W'(1);
                end
            end

            if (cmd.time_zero)
            begin
                elapsed_reg   <= '0;
                cur_stamp_reg <= STAMP_ONE;
            end
            else if (cmd.time_tick && in_time)
            begin
                elapsed_reg   <= elapsed_reg + (STAMP_BITS + 1)'(1);
                cur_stamp_reg <= (cur_stamp_reg == STAMP_TOP) ? STAMP_ONE
                                                              : cur_stamp_reg + STAMP_ONE;
            end

            if (cmd.result_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.req_type    = req_type_reg;
        status.cnt_zero    = (cnt_reg == '0);
        status.hash_last   = ({1'b0, hash_k_reg} == (cnt_reg - CNT_W'(1)));
        status.addr_last   = (addr_reg == SLOT_AW'(SLOTS - 1));
        status.expired_hit = expired_flag_reg;
        status.rsp_free    = !rsp_valid_reg || !rsp_stall;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/time_decaying_bloom_filter_unit.sv
// ----------------------------------------------------------------------------
// Time-decaying Bloom filter unit
// Timestamp-slot Bloom filter with expiry checks, sweeps and a seconds count.
// ----------------------------------------------------------------------------
//  Channel   Signals                         Role
//  req       req_valid, req_stall, req_data  one request item in
//  rsp       rsp_valid, rsp_stall, rsp_data  one result item out per request
//  cfg       cfg_wr_en, cfg_wr_data          timeout register write
//
// Items are handled one at a time, and the controller returns to idle before the
// next accept. After reset the table is zeroed by a pass over all SLOTS slots
// before req_stall drops. A stalled result holds back only the result of the
// following request.
// ----------------------------------------------------------------------------
`default_nettype none

`include "time_decaying_bloom_filter_unit_assert.svh"

module time_decaying_bloom_filter_unit #(
    parameter int STAMP_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire tdbf_pkg::req_item_t            req_data,
    output logic                                rsp_valid,
    input  wire logic                           rsp_stall,
    output tdbf_pkg::rsp_item_t                 rsp_data,
    input  wire logic                           cfg_wr_en,
    input  wire logic [tdbf_pkg::TIMEOUT_W-1:0] cfg_wr_data
);

    import tdbf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       req_accept;

    assign req_accept = req_valid && !req_stall;

    tdbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tdbf_datapath #(
        .STAMP_BITS (STAMP_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_data    (req_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data)
    );

    `TDBF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_accept, req_stall, "request accepted while busy")
    `TDBF_ASSERT_IMPL(a_clear_blocks_req, clk, rst_n, cmd.clr_wr, req_stall, "request taken during table clear")
    `TDBF_ASSERT_IMPL(a_result_slot_free, clk, rst_n, cmd.result_load, (!rsp_valid || !rsp_stall), "result overwrote a held item")

endmodule

`default_nettype wire

>>> bench/time_decaying_bloom_filter_unit_tb.sv
// ----------------------------------------------------------------------------
// Time-decaying Bloom filter unit testbench
// A short table of requests, some with fixed answers, opens the run. Several
// phases of random requests follow, each under its own timeout setting.
// Other results are checked field by field against a behavioral model of the
// slot table, the stamp clock and the sweeps. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module time_decaying_bloom_filter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tdbf_pkg::*;

    localparam int STAMP_TOP    = (1 << 16) - 1;
    localparam int EXPIRY_TOP   = 65534;
    localparam int PHASE_ITEMS  = 250;
    localparam int RUN_LIMIT    = 6_000_000;
    localparam int POOL_DEPTH   = 32;
    localparam req_code_t REQ_CODE_TOP = '1;

    localparam logic [8*SLOT_AW-1:0] INDEX_SET_A =
        {12'd0, 12'd4095, 12'h555, 12'hAAA, 12'd1, 12'd2, 12'd3, 12'd4};
    localparam logic [8*SLOT_AW-1:0] INDEX_SET_B =
        {12'h800, 12'h7FF, 12'h123, 12'hFED, 12'd0, 12'd4095, 12'h0F0, 12'hF0F};

    localparam rsp_item_t QUIET_RSP   = '0;
    localparam rsp_item_t PRESENT_RSP = {1'b1, 1'b0, 13'd0};

    typedef struct {
        bit        cfg_row;
        int        cfg_value;
        req_item_t item;
        bit        fixed;
        rsp_item_t want;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_item_t            req_data = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_item_t            rsp_data;
    logic                 cfg_wr_en = 1'b0;
    logic [TIMEOUT_W-1:0] cfg_wr_data = '0;

    logic [15:0] stamp_table [SLOTS];
    int          seconds_elapsed = 0;
    int          expiry_limit = int'(TIMEOUT_RESET);
    rsp_item_t   answers_due [$];
    req_item_t   known_elements [$];
    plan_row_t   opening_rows [$];

    int fault_count = 0;
    int results_seen = 0;
    int items_sent = 0;
    int sweeps_sent = 0;
    int peak_elapsed = 0;
    int cycle_count = 0;
    bit tx_armed = 1'b0;
    bit tx_calm = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    time_decaying_bloom_filter_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        foreach (stamp_table[i])
        begin
            stamp_table[i] = '0;
        end
    end

    function automatic int stamp_now();
        return (seconds_elapsed % STAMP_TOP) + 1;
    endfunction

    function automatic bit slot_stale(int v);
        return v != 0 && ((stamp_now() + STAMP_TOP - v) % STAMP_TOP) > expiry_limit;
    endfunction

    function automatic bit slot_live(int v);
        return v != 0 && ((stamp_now() + STAMP_TOP - v) % STAMP_TOP) <= expiry_limit;
    endfunction

    function automatic int slot_pick(req_item_t it, int k);
        logic [8*SLOT_AW-1:0] idx_bits;
        idx_bits = it[8*SLOT_AW-1:0];
        return idx_bits[(7 - k)*SLOT_AW +: SLOT_AW];
    endfunction

    function automatic rsp_item_t bloom_answer(req_item_t it);
        rsp_item_t r;
        int        n;
        int        tally;
        bit        hit;
        r = '0;
        tally = 0;
        n = (it.index_count > MAX_HASHES) ? MAX_HASHES : int'(it.index_count);
        case (it.req_type)
            REQ_ADD:
            begin
                for (int k = 0; k < n; k++)
                begin
                    stamp_table[slot_pick(it, k)] = 16'(stamp_now());
                end
            end
            REQ_LOOKUP:
            begin
                hit = seconds_elapsed <= STAMP_TOP;
                for (int k = 0; k < n; k++)
                begin
                    if (!slot_live(stamp_table[slot_pick(it, k)]))
                    begin
                        hit = 1'b0;
                    end
                end
                r.present = hit;
            end
            REQ_HAS_EXPIRED, REQ_RESET_IF_EXP:
            begin
                hit = 1'b0;
                for (int k = 0; k < n; k++)
                begin
                    if (slot_stale(stamp_table[slot_pick(it, k)]))
                    begin
                        hit = 1'b1;
                    end
                end
                r.expired = hit;
                if (it.req_type == REQ_RESET_IF_EXP && hit)
                begin
                    for (int k = 0; k < n; k++)
                    begin
                        stamp_table[slot_pick(it, k)] = 16'(stamp_now());
                    end
                end
            end
            REQ_CLEAR_EXPIRED:
            begin
                foreach (stamp_table[i])
                begin
                    if (slot_stale(stamp_table[i]))
                    begin
                        stamp_table[i] = '0;
                        tally++;
                    end
                end
            end
            REQ_COUNT_EXPIRED:
            begin
                foreach (stamp_table[i])
                begin
                    if (slot_stale(stamp_table[i]))
                    begin
                        tally++;
                    end
                end
            end
            REQ_COUNT_LIVE:
            begin
                foreach (stamp_table[i])
                begin
                    if (slot_live(stamp_table[i]))
                    begin
                        tally++;
                    end
                end
            end
            REQ_CLEAR_ALL:
            begin
                foreach (stamp_table[i])
                begin
                    stamp_table[i] = '0;
                end
                seconds_elapsed = 0;
            end
            REQ_TICK:
            begin
                if (seconds_elapsed <= STAMP_TOP)
                begin
                    seconds_elapsed++;
                end
            end
            REQ_RESTART_TIME:
            begin
                seconds_elapsed = 0;
            end
            default:
            begin
            end
        endcase
        r.slot_total = (tally > int'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(tally);
        return r;
    endfunction

    function automatic int pause_len(bit calm);
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic req_item_t fresh_element();
        req_item_t it;
        int        r;
        it = '0;
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            it.index_count = '0;
        end
        else if (r == 1)
        begin
            it.index_count = CNT_W'($urandom_range(MAX_HASHES + 1, 15));
        end
        else
        begin
            it.index_count = CNT_W'($urandom_range(1, MAX_HASHES));
        end
        it.slot_index_0 = SLOT_AW'($urandom_range(0, SLOTS - 1));
        it.slot_index_1 = SLOT_AW'($urandom_range(0, SLOTS - 1));
        it.slot_index_2 = SLOT_AW'($urandom_range(0, SLOTS - 1));
        it.slot_index_3 = SLOT_AW'($urandom_range(0, SLOTS - 1));
        it.slot_index_4 = SLOT_AW'($urandom_range(0, SLOTS - 1));
        it.slot_index_5 = SLOT_AW'($urandom_range(0, SLOTS - 1));
        it.slot_index_6 = SLOT_AW'($urandom_range(0, SLOTS - 1));
        it.slot_index_7 = SLOT_AW'($urandom_range(0, SLOTS - 1));
        return it;
    endfunction

    function automatic req_item_t pick_element();
        if (known_elements.size() != 0 && $urandom_range(0, 9) < 6)
        begin
            return known_elements[$urandom_range(0, known_elements.size() - 1)];
        end
        return fresh_element();
    endfunction

    function automatic plan_row_t op_row(req_code_t op, int cnt, bit alt, bit fixed,
                                         rsp_item_t want);
        plan_row_t row;
        row.cfg_row = 1'b0;
        row.cfg_value = 0;
        row.item = {op, CNT_W'(cnt), alt ? INDEX_SET_B : INDEX_SET_A};
        row.fixed = fixed;
        row.want = want;
        return row;
    endfunction

    function automatic plan_row_t cfg_row_of(int v);
        plan_row_t row;
        row.cfg_row = 1'b1;
        row.cfg_value = v;
        row.item = '0;
        row.fixed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    task automatic send_item(input req_item_t it, input bit fixed = 1'b0,
                             input rsp_item_t want = '0);
        rsp_item_t guess;
        int        g;
        req_data <= it;
        req_valid <= 1'b1;
        tx_armed = 1'b0;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        guess = bloom_answer(it);
        answers_due.push_back(fixed ? want : guess);
        items_sent++;
        if (it.req_type inside {REQ_CLEAR_EXPIRED, REQ_COUNT_EXPIRED, REQ_COUNT_LIVE,
                                REQ_CLEAR_ALL})
        begin
            sweeps_sent++;
        end
        if (seconds_elapsed > peak_elapsed)
        begin
            peak_elapsed = seconds_elapsed;
        end
        g = pause_len(tx_calm);
        if (g > 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        else
        begin
            tx_armed = 1'b1;
        end
    endtask

    task automatic settle();
        if (tx_armed)
        begin
            req_valid <= 1'b0;
            tx_armed = 1'b0;
        end
        while (answers_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic set_expiry(input int v);
        settle();
        cfg_wr_data <= TIMEOUT_W'(v);
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        expiry_limit = v;
    endtask

    task automatic issue_random_item(input bit keep_clock);
        req_item_t it;
        req_code_t op;
        int        r;
        it = pick_element();
        r = $urandom_range(0, 999);
        if (r < 250)
        begin
            op = REQ_ADD;
        end
        else if (r < 470)
        begin
            op = REQ_LOOKUP;
        end
        else if (r < 570)
        begin
            op = REQ_HAS_EXPIRED;
        end
        else if (r < 670)
        begin
            op = REQ_RESET_IF_EXP;
        end
        else if (r < 880)
        begin
            op = REQ_TICK;
        end
        else if (r < 900)
        begin
            op = REQ_RESTART_TIME;
        end
        else if (r < 920)
        begin
            op = req_code_t'($urandom_range(REQ_RESTART_TIME + 1, REQ_CODE_TOP));
        end
        else if (r < 930)
        begin
            op = REQ_CLEAR_EXPIRED;
        end
        else if (r < 940)
        begin
            op = REQ_COUNT_EXPIRED;
        end
        else if (r < 950)
        begin
            op = REQ_COUNT_LIVE;
        end
        else if (r < 955)
        begin
            op = REQ_CLEAR_ALL;
        end
        else
        begin
            op = REQ_LOOKUP;
            it = fresh_element();
        end
        if (keep_clock && (op == REQ_RESTART_TIME || op == REQ_CLEAR_ALL))
        begin
            op = REQ_LOOKUP;
        end
        it.req_type = op;
        if (op == REQ_ADD)
        begin
            known_elements.push_back(it);
            if (known_elements.size() > POOL_DEPTH)
            begin
                void'(known_elements.pop_front());
            end
        end
        send_item(it);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int n;
        forever
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                repeat ($urandom_range(100, 400)) @(posedge clk);
            end
            n = pause_len(1'b0);
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    task automatic log_mismatch(input string field, input logic [TOTAL_W-1:0] want,
                                input logic [TOTAL_W-1:0] got);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("result %0d: %s expected %0d, got %0d", results_seen, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            results_seen++;
            if (answers_due.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                begin
                    $display("result %0d arrived with no request outstanding", results_seen);
                end
            end
            else
            begin
                want = answers_due.pop_front();
                if (rsp_data.present !== want.present)
                begin
                    log_mismatch("present", want.present, rsp_data.present);
                end
                if (rsp_data.expired !== want.expired)
                begin
                    log_mismatch("expired", want.expired, rsp_data.expired);
                end
                if (rsp_data.slot_total !== want.slot_total)
                begin
                    log_mismatch("slot_total", want.slot_total, rsp_data.slot_total);
                end
            end
        end
    end

    initial
    begin
        int phase_limits [5];
        phase_limits = '{int'(TIMEOUT_RESET), 0, 5, EXPIRY_TOP, $urandom_range(1, 300)};
        opening_rows = '{
            op_row(REQ_COUNT_LIVE, 8, 1'b0, 1'b1, QUIET_RSP),
            op_row(REQ_LOOKUP, 1, 1'b0, 1'b1, QUIET_RSP),
            op_row(REQ_LOOKUP, 0, 1'b0, 1'b1, PRESENT_RSP),
            op_row(REQ_HAS_EXPIRED, 0, 1'b0, 1'b1, QUIET_RSP),
            op_row(REQ_ADD, 8, 1'b0, 1'b1, QUIET_RSP),
            op_row(REQ_LOOKUP, 8, 1'b0, 1'b0, QUIET_RSP),
            op_row(REQ_ADD, 15, 1'b1, 1'b0, QUIET_RSP),
            op_row(REQ_COUNT_LIVE, 8, 1'b0, 1'b0, QUIET_RSP),
            cfg_row_of(0),
            op_row(REQ_TICK, 8, 1'b0, 1'b1, QUIET_RSP),
            op_row(REQ_HAS_EXPIRED, 8, 1'b0, 1'b0, QUIET_RSP),
            op_row(REQ_LOOKUP, 8, 1'b1, 1'b0, QUIET_RSP),
            op_row(REQ_RESET_IF_EXP, 2, 1'b0, 1'b0, QUIET_RSP),
            op_row(REQ_LOOKUP, 2, 1'b0, 1'b0, QUIET_RSP),
            op_row(REQ_COUNT_EXPIRED, 8, 1'b0, 1'b0, QUIET_RSP),
            op_row(REQ_CLEAR_EXPIRED, 8, 1'b0, 1'b0, QUIET_RSP),
            op_row(REQ_COUNT_LIVE, 8, 1'b0, 1'b0, QUIET_RSP),
            op_row(REQ_RESTART_TIME, 8, 1'b0, 1'b1, QUIET_RSP),
            op_row(REQ_CODE_TOP, 8, 1'b1, 1'b1, QUIET_RSP),
            cfg_row_of(EXPIRY_TOP),
            op_row(REQ_ADD, 3, 1'b1, 1'b0, QUIET_RSP),
            op_row(REQ_LOOKUP, 9, 1'b1, 1'b0, QUIET_RSP),
            op_row(REQ_CLEAR_ALL, 8, 1'b0, 1'b1, QUIET_RSP),
            op_row(REQ_COUNT_LIVE, 8, 1'b0, 1'b1, QUIET_RSP),
            op_row(REQ_LOOKUP, 0, 1'b1, 1'b1, PRESENT_RSP)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening_rows[i])
        begin
            if (opening_rows[i].cfg_row)
            begin
                set_expiry(opening_rows[i].cfg_value);
            end
            else
            begin
                send_item(opening_rows[i].item, opening_rows[i].fixed, opening_rows[i].want);
            end
        end

        foreach (phase_limits[p])
        begin
            set_expiry(phase_limits[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 50 == 0)
                begin
                    tx_calm = ($urandom_range(0, 3) == 0);
                end
                if (p == 1 && i == PHASE_ITEMS / 2)
                begin
                    settle();
                end
                issue_random_item(1'b0);
            end
            tx_calm = 1'b0;
        end

        settle();
        repeat (20) @(posedge clk);

        $display("Sent %0d requests, %0d of them table sweeps, and checked %0d results.",
                 items_sent, sweeps_sent, results_seen);
        $display("Elapsed count peaked at %0d against a ceiling of %0d; %0d faults logged.",
                 peak_elapsed, STAMP_TOP + 1, fault_count);
        if (fault_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
